[sv/dpc_pkg.sv]
// Shared constants, result type and reciprocal table for the defective pixel corrector.
// No dependencies.
`default_nettype none
package dpc_pkg;

  localparam int DpcMaxLineWidth = 4096;
  localparam int CmpW            = 14;   // compare width, holds any width up to 8192

  localparam logic [12:0] LineWidthRst = 13'd2464;
  localparam logic [15:0] FrameHeightRst = 16'd2056;
  localparam logic [7:0]  ThresholdRst = 8'd10;
  localparam logic [7:0]  PixMax = 8'd255;

  localparam logic [1:0] RegLineWidth   = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;
  localparam logic [1:0] RegThreshold   = 2'd2;

  typedef struct packed {
    logic [7:0] pixel;
    logic       mark;
  } dpc_res_t;

  // ceil(2^16 / n); exact floor division for sums below 2048
  function automatic logic [16:0] dpc_recip(input logic [3:0] n);
    logic [16:0] r;
    begin
      unique case (n)
        4'd1:    r = 17'd65536;
        4'd2:    r = 17'd32768;
        4'd3:    r = 17'd21846;
        4'd4:    r = 17'd16384;
        4'd5:    r = 17'd13108;
        4'd6:    r = 17'd10923;
        4'd7:    r = 17'd9363;
        4'd8:    r = 17'd8192;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

[sv/defective_pixel_correction.sv]
// Streaming 3x3 defective pixel correction for 8-bit grey pixels.
// A transaction that yields a result passes the read, detect, correct and output states;
// one that yields none ends after correct, and a drain tick during the fill phase is taken
// in idle alone. The input is taken again only from idle, so a stalled output holds it.
// Results trail their input by 2 lines + 2 pixels.
// Reset clears state, config, counters, windows and tvalid, but not line-store RAMs or data.
// Depends on dpc_pkg, dpc_ram, dpc_detect, dpc_correct.
`default_nettype none
module defective_pixel_correction import dpc_pkg::*; #(
  parameter int MAX_LINE_WIDTH = DpcMaxLineWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
  input  wire logic        s_axis_tuser,   // [0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata,   // [7:0] pixel_out
  output logic             m_axis_tlast,   // line_end
  output logic      [1:0]  m_axis_tuser,   // [0] was_defective, [1] frame_end
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_LINE_WIDTH);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDet  = 2'd1;
  localparam logic [1:0] StCor  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [12:0] lw_q;
  logic [15:0] fh_q;
  logic [7:0]  thr_q;

  logic [CW-1:0] in_col_q, out_col_q, col_q;
  logic [16:0]   in_row_q, out_row_q;
  logic [7:0]    pix_q;
  logic          emit_q, det_int_q;

  logic [CmpW-1:0] w, c_ext, oc_ext;
  logic [16:0]     h;
  logic            in_acc, drop, emit, det_int, out_int, line_end, frame_end, out_load;
  logic [15:0]     raw_rd;
  logic [17:0]     mrk_rd;
  logic [8:0]      marked;
  dpc_res_t        res;

  // effective sizes
  always_comb begin
    if (lw_q < 13'd3) w = CmpW'(3);
    else if (CmpW'(lw_q) > CmpW'(MAX_LINE_WIDTH)) w = CmpW'(MAX_LINE_WIDTH);
    else w = CmpW'(lw_q);
    h = (fh_q < 16'd3) ? 17'd3 : {1'b0, fh_q};
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign drop          = (in_row_q < h) && s_axis_tuser;

  assign c_ext   = CmpW'(in_col_q);
  assign oc_ext  = CmpW'(out_col_q);
  assign emit    = (in_row_q > 17'd2) || (in_row_q == 17'd2 && c_ext >= CmpW'(2));
  assign det_int = c_ext >= CmpW'(2) && c_ext + CmpW'(1) <= w &&
                   in_row_q >= 17'd2 && in_row_q + 17'd1 <= h;
  assign out_int = out_row_q >= 17'd1 && out_row_q + 17'd2 <= h &&
                   oc_ext >= CmpW'(1) && oc_ext + CmpW'(2) <= w;
  assign line_end  = oc_ext + CmpW'(1) >= w;
  assign frame_end = line_end && out_row_q + 17'd1 >= h;
  assign out_load  = (state_q == StOut) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc && !drop) state_d = StDet;
      StDet:  state_d = StCor;
      StCor:  state_d = emit_q ? StOut : StIdle;
      StOut:  if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lw_q    <= LineWidthRst;
      fh_q    <= FrameHeightRst;
      thr_q   <= ThresholdRst;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegLineWidth:   lw_q  <= cfg_data_i[12:0];
          RegFrameHeight: fh_q  <= cfg_data_i;
          RegThreshold:   thr_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (in_acc && !drop) begin
      if (c_ext + CmpW'(1) >= w) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + 17'd1;
      end else begin
        in_col_q <= in_col_q + CW'(1);
      end
    end else if (out_load) begin
      if (frame_end) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else if (line_end) begin
        out_col_q <= '0;
        out_row_q <= out_row_q + 17'd1;
      end else begin
        out_col_q <= out_col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !drop) begin
      col_q     <= in_col_q;
      pix_q     <= (in_row_q < h) ? s_axis_tdata : 8'd0;
      emit_q    <= emit;
      det_int_q <= det_int;
    end
  end

  dpc_ram #(.WIDTH(16), .DEPTH(MAX_LINE_WIDTH)) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == StDet),
    .waddr_i (col_q),
    .wdata_i ({pix_q, raw_rd[15:8]}),
    .re_i    (in_acc && !drop),
    .raddr_i (in_col_q),
    .rdata_o (raw_rd)
  );

  dpc_ram #(.WIDTH(18), .DEPTH(MAX_LINE_WIDTH)) u_mrk_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == StCor),
    .waddr_i (col_q),
    .wdata_i ({marked, mrk_rd[17:9]}),
    .re_i    (in_acc && !drop),
    .raddr_i (in_col_q),
    .rdata_o (mrk_rd)
  );

  dpc_detect u_detect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (state_q == StDet),
    .top_i      (raw_rd[7:0]),
    .mid_i      (raw_rd[15:8]),
    .bot_i      (pix_q),
    .interior_i (det_int_q),
    .thr_i      (thr_q),
    .marked_o   (marked)
  );

  dpc_correct u_correct (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (state_q == StCor),
    .top_i      (mrk_rd[8:0]),
    .mid_i      (mrk_rd[17:9]),
    .bot_i      (marked),
    .interior_i (out_int),
    .res_o      (res)
  );

  // output register; holds until the downstream transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= res.pixel;
      m_axis_tlast <= line_end;
      m_axis_tuser <= {frame_end, res.mark};
    end
  end

endmodule
`default_nettype wire

[sv/dpc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[sv/dpc_detect.sv]
// Raw 3x3 window and defect marking: stuck at 0 or 255, or too far from the neighbour mean.
// Depends on dpc_pkg.
`default_nettype none
module dpc_detect import dpc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       shift_i,
  input  wire logic [7:0] top_i,
  input  wire logic [7:0] mid_i,
  input  wire logic [7:0] bot_i,
  input  wire logic       interior_i,
  input  wire logic [7:0] thr_i,
  output logic      [8:0] marked_o
);

  logic [7:0]  win_q [9];
  logic [7:0]  win_d [9];
  logic [10:0] sum;
  logic [7:0]  mean, centre, diff;
  logic        mark;
  logic [8:0]  marked_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]   = win_q[k*3+1];
      win_d[k*3+1] = win_q[k*3+2];
    end
    win_d[2] = top_i;
    win_d[5] = mid_i;
    win_d[8] = bot_i;
    sum = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) sum = sum + 11'(win_d[k]);
    end
    mean   = sum[10:3];
    centre = win_d[4];
    diff   = (centre >= mean) ? centre - mean : mean - centre;
    mark   = interior_i && (centre == '0 || centre == PixMax || diff > thr_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else if (shift_i) begin
      for (int k = 0; k < 9; k++) win_q[k] <= win_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) marked_q <= {mark, centre};
  end

  assign marked_o = marked_q;

endmodule
`default_nettype wire

[sv/dpc_correct.sv]
// Marked 3x3 window, sum and count of clean neighbours, reciprocal divide.
// Depends on dpc_pkg.
`default_nettype none
module dpc_correct import dpc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       shift_i,
  input  wire logic [8:0] top_i,
  input  wire logic [8:0] mid_i,
  input  wire logic [8:0] bot_i,
  input  wire logic       interior_i,
  output dpc_res_t        res_o
);

  logic [8:0]  win_q [9];
  logic [8:0]  win_d [9];
  logic [10:0] sum, sum_q;
  logic [3:0]  cnt, cnt_q;
  logic [7:0]  centre_q;
  logic        mark_q;
  logic [27:0] prod;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]   = win_q[k*3+1];
      win_d[k*3+1] = win_q[k*3+2];
    end
    win_d[2] = top_i;
    win_d[5] = mid_i;
    win_d[8] = bot_i;
    sum = '0;
    cnt = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4 && !win_d[k][8]) begin
        sum = sum + 11'(win_d[k][7:0]);
        cnt = cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else if (shift_i) begin
      for (int k = 0; k < 9; k++) win_q[k] <= win_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sum_q    <= sum;
      cnt_q    <= cnt;
      centre_q <= win_d[4][7:0];
      mark_q   <= interior_i && win_d[4][8];
    end
  end

  assign prod = 28'(sum_q) * 28'(dpc_recip(cnt_q));

  always_comb begin
    res_o.mark  = mark_q;
    res_o.pixel = (mark_q && cnt_q != '0) ? prod[23:16] : centre_q;
  end

endmodule
`default_nettype wire

[tb/tb_defective_pixel_correction.sv]
// Self-checking testbench for defective_pixel_correction: streams small frames with sparse
// defects, predicts every result with a behavioral corrector and compares them in order.
// Depends on dpc_pkg and the defective_pixel_correction RTL.
`default_nettype none
module tb_defective_pixel_correction;
  import dpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StoreSpan  = 4096;
  localparam int IdleLimit  = 20000;
  localparam int LongHold   = 2000;

  typedef struct {
    bit         drain;
    logic [7:0] pixel;
  } pix_item_t;

  typedef struct {
    logic [7:0] pixel;
    logic       defective;
    logic       line_end;
    logic       frame_end;
  } pix_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] pixel_in
  logic        s_axis_tuser = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] pixel_out
  logic        m_axis_tlast;        // line_end
  logic [1:0]  m_axis_tuser;        // [0] was_defective, [1] frame_end
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  defective_pixel_correction dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow registers and predictor state
  logic [12:0] width_reg = LineWidthRst;
  logic [15:0] height_reg = FrameHeightRst;
  logic [7:0]  thresh_reg = ThresholdRst;
  logic [7:0]  raw_lines [2*StoreSpan];
  logic [8:0]  marked_lines [2*StoreSpan];
  logic [7:0]  det_win [9];
  logic [8:0]  cor_win [9];
  int in_col = 0, in_row = 0, out_col = 0, out_row = 0;

  pix_item_t   pending_pixels[$];
  pix_result_t expected_pixels[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  items_sent = 0;
  bit  in_fire = 1'b0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  int  send_gap = 0;
  int  recv_hold = 0;

  function automatic int eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > StoreSpan) return StoreSpan;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg < 3) ? 3 : int'(height_reg);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic correct_pixel(input bit drain, input logic [7:0] pix);
    int w, h, c, r, dx, dy, sum, cnt, mean, diff, centre;
    logic [7:0] a, b, v;
    logic [8:0] ma, mb, mk;
    bit interior, mark, lend, fend;
    pix_result_t res;
    w = eff_width();
    h = eff_height();
    c = in_col;
    r = in_row;
    v = pix;
    if (r < h) begin
      if (drain) return;
    end else begin
      v = 8'd0;
    end
    if (c >= StoreSpan) c = 0;
    a = raw_lines[c];
    b = raw_lines[StoreSpan + c];
    raw_lines[c] = b;
    raw_lines[StoreSpan + c] = v;
    for (int k = 0; k < 3; k++) begin
      det_win[k*3] = det_win[k*3+1];
      det_win[k*3+1] = det_win[k*3+2];
    end
    det_win[2] = a;
    det_win[5] = b;
    det_win[8] = v;
    if (c >= 1) begin
      dx = c - 1; dy = r - 1;
    end else begin
      dx = w - 1; dy = r - 2;
    end
    interior = dy >= 1 && dy <= h - 2 && dx >= 1 && dx <= w - 2;
    centre = det_win[4];
    mark = 1'b0;
    if (interior) begin
      sum = 0;
      for (int k = 0; k < 9; k++) if (k != 4) sum += det_win[k];
      mean = sum >> 3;
      diff = (centre >= mean) ? centre - mean : mean - centre;
      mark = centre == 0 || centre == PixMax || diff > thresh_reg;
    end
    mk = {mark, centre[7:0]};
    ma = marked_lines[c];
    mb = marked_lines[StoreSpan + c];
    marked_lines[c] = mb;
    marked_lines[StoreSpan + c] = mk;
    for (int k = 0; k < 3; k++) begin
      cor_win[k*3] = cor_win[k*3+1];
      cor_win[k*3+1] = cor_win[k*3+2];
    end
    cor_win[2] = ma;
    cor_win[5] = mb;
    cor_win[8] = mk;
    in_col = c + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row = r + 1;
    end
    if (!(r > 2 || (r == 2 && c >= 2))) return;
    interior = out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w;
    centre = cor_win[4][7:0];
    mark = interior && cor_win[4][8];
    if (mark) begin
      sum = 0;
      cnt = 0;
      for (int k = 0; k < 9; k++) begin
        if (k != 4 && !cor_win[k][8]) begin
          sum += cor_win[k][7:0];
          cnt++;
        end
      end
      if (cnt > 0) centre = sum / cnt;
    end
    lend = out_col + 1 >= w;
    fend = lend && out_row + 1 >= h;
    res.pixel = centre[7:0];
    res.defective = mark;
    res.line_end = lend;
    res.frame_end = fend;
    expected_pixels.push_back(res);
    if (fend) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else if (lend) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // input transactions: predict on acceptance
  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) correct_pixel(s_axis_tuser, s_axis_tdata);
  end

  always @(negedge clk_i) begin
    if (rst_ni && (in_fire || !s_axis_tvalid)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        pix_item_t it;
        it = pending_pixels.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= it.pixel;
        s_axis_tuser <= it.drain;
        send_gap = no_idle ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random holds plus one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      recv_hold = LongHold;
      m_axis_tready <= 1'b0;
    end else if (no_idle || $urandom_range(0, 99) < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      recv_hold = pick_gap();
      m_axis_tready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result, pixel", m_axis_tdata, -1);
      end else begin
        pix_result_t e;
        e = expected_pixels.pop_front();
        if (m_axis_tdata !== e.pixel) report_mismatch("pixel_out", m_axis_tdata, e.pixel);
        if (m_axis_tuser[0] !== e.defective)
          report_mismatch("was_defective", m_axis_tuser[0], e.defective);
        if (m_axis_tlast !== e.line_end) report_mismatch("line_end", m_axis_tlast, e.line_end);
        if (m_axis_tuser[1] !== e.frame_end)
          report_mismatch("frame_end", m_axis_tuser[1], e.frame_end);
      end
    end
  end

  // watchdog on stalled handshakes
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegLineWidth:   width_reg = data[12:0];
      RegFrameHeight: height_reg = data;
      RegThreshold:   thresh_reg = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_pixel(input bit drain, input logic [7:0] pix);
    pix_item_t it;
    it.drain = drain;
    it.pixel = pix;
    pending_pixels.push_back(it);
    if (!drain) items_sent++;
  endtask

  // hold until the block is empty, then let any ignored ticks settle
  task automatic wait_drained();
    while (pending_pixels.size() > 0 || expected_pixels.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_flush();
    int n;
    n = 2 * eff_width() + 2;
    // pixel values sent during flush are replaced by zero in the block
    for (int i = 0; i < n; i++) push_pixel(1'($urandom_range(0, 1)), 8'($urandom));
    if ($urandom_range(0, 3) == 0) push_pixel(1'b1, 8'($urandom));
  endtask

  task automatic send_frame();
    int w, h, base, v, r;
    w = eff_width();
    h = eff_height();
    base = $urandom_range(20, 235);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 99) < 3) push_pixel(1'b1, 8'($urandom));
      r = $urandom_range(0, 99);
      if (r < 4) v = 0;
      else if (r < 8) v = 255;
      else if (r < 14) v = $urandom_range(0, 255);
      else begin
        v = base + $urandom_range(0, 24) - 12;
        if (v < 1) v = 1;
        if (v > 254) v = 254;
      end
      push_pixel(1'b0, 8'(v));
    end
    send_flush();
  endtask

  initial begin
    int frame_no;
    for (int i = 0; i < 2 * StoreSpan; i++) begin
      raw_lines[i] = '0;
      marked_lines[i] = '0;
    end
    for (int i = 0; i < 9; i++) begin
      det_win[i] = '0;
      cor_win[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: smallest frame, zero threshold, stuck-low and stuck-high pixels
    write_reg(RegLineWidth, 16'd3);
    write_reg(RegFrameHeight, 16'd3);
    write_reg(RegThreshold, 16'd0);
    push_pixel(1'b0, 8'd10);  push_pixel(1'b0, 8'd0);   push_pixel(1'b0, 8'd20);
    push_pixel(1'b1, 8'd77);  // ignored while the frame fills
    push_pixel(1'b0, 8'd255); push_pixel(1'b0, 8'd0);   push_pixel(1'b0, 8'd40);
    push_pixel(1'b0, 8'd50);  push_pixel(1'b0, 8'd255); push_pixel(1'b0, 8'd60);
    send_flush();
    wait_drained();

    // clamped sizes, widest threshold
    write_reg(RegLineWidth, 16'd0);
    write_reg(RegFrameHeight, 16'd0);
    write_reg(RegThreshold, 16'd255);
    send_frame();
    wait_drained();

    frame_no = 0;
    while (items_sent < 1550) begin
      if (frame_no == 5) begin
        // longer line; bits above the width field are dropped, leaving 64
        write_reg(RegLineWidth, 16'hE040);
        write_reg(RegFrameHeight, 16'd3);
      end else begin
        write_reg(RegLineWidth, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(9, 40))
                                                              : 16'($urandom_range(1, 8)));
        write_reg(RegFrameHeight, 16'($urandom_range(2, 8)));
      end
      case ($urandom_range(0, 3))
        0: write_reg(RegThreshold, 16'd0);
        1: write_reg(RegThreshold, 16'd255);
        default: write_reg(RegThreshold, 16'($urandom_range(0, 40)));
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      if (frame_no == 3) hold_req = 1'b1;
      send_frame();
      wait_drained();
      no_idle = 1'b0;
      frame_no++;
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

[defective_pixel_correction.f]
sv/dpc_pkg.sv
sv/dpc_ram.sv
sv/dpc_detect.sv
sv/dpc_correct.sv
sv/defective_pixel_correction.sv
tb/tb_defective_pixel_correction.sv
